@@ rtl/spu_adpcm_pkg.sv @@
// Shared types, constants and filter tables for the SPU ADPCM decoder.
`timescale 1ns / 1ps

package spu_adpcm_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned PosW       = 4;
  localparam int unsigned FilterMax  = 4;
  localparam int unsigned QueueDepth = 2;
  localparam logic [1:0]  LoopFlags  = 2'b11;

  // one data byte plus the block context it decodes under
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] shift;
    logic [2:0] filter;
    logic [1:0] flags;
    logic       last_byte;  // byte 15 of its block
    logic       clear_taps; // first data byte after a start marker
  } entry_t;

  function automatic logic signed [7:0] coef_newer(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      default: c = 8'sd122;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_older(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd0;
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      default: c = -8'sd60;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/spu_adpcm_front.sv @@
// Front end: block framing, header capture and data byte dispatch.
`timescale 1ns / 1ps

module spu_adpcm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_of_stream_i,
  output logic                  push_o,
  output spu_adpcm_pkg::entry_t entry_o
);

  logic [spu_adpcm_pkg::PosW-1:0] pos_q, pos_d, pos_cur;
  logic [3:0] shift_q, shift_d;
  logic [2:0] filter_q, filter_d;
  logic [1:0] flags_q, flags_d;
  logic       clr_q, clr_d;

  always_comb begin
    pos_cur  = start_of_stream_i ? '0 : pos_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    filter_d = filter_q;
    flags_d  = flags_q;
    clr_d    = clr_q;
    push_o   = 1'b0;
    if (accept_i) begin
      pos_d = pos_cur + 1'b1;
      if (start_of_stream_i) clr_d = 1'b1;
      if (pos_cur == '0) begin
        shift_d  = data_byte_i[3:0];
        filter_d = (data_byte_i[7:4] > 4'(spu_adpcm_pkg::FilterMax))
                   ? 3'(spu_adpcm_pkg::FilterMax) : data_byte_i[6:4];
      end else if (pos_cur == 4'd1) begin
        flags_d = data_byte_i[1:0];
      end else begin
        push_o = 1'b1;
        clr_d  = 1'b0;
      end
    end
    entry_o.data       = data_byte_i;
    entry_o.shift      = shift_q;
    entry_o.filter     = filter_q;
    entry_o.flags      = flags_q;
    entry_o.last_byte  = (pos_cur == 4'(spu_adpcm_pkg::BlockBytes - 1));
    entry_o.clear_taps = clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      filter_q <= '0;
      flags_q  <= '0;
      clr_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      filter_q <= filter_d;
      flags_q  <= flags_d;
      clr_q    <= clr_d;
    end
  end

endmodule

@@ rtl/spu_adpcm_queue.sv @@
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps

module spu_adpcm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  spu_adpcm_pkg::entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output spu_adpcm_pkg::entry_t entry_o
);

  localparam int unsigned Depth = spu_adpcm_pkg::QueueDepth;

  spu_adpcm_pkg::entry_t mem_q [Depth];
  logic [$clog2(Depth)-1:0] wptr_q, rptr_q;
  logic [$clog2(Depth):0]   cnt_q;

  assign full_o  = (cnt_q == ($clog2(Depth)+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/spu_adpcm_back.sv @@
// Back end: nibble decode, two-tap prediction, clamp and output register.
`timescale 1ns / 1ps

module spu_adpcm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  spu_adpcm_pkg::entry_t entry_i,
  output logic                  pop_o,
  output logic signed [15:0]    pcm_sample_o,
  output logic                  pair_last_o,
  output logic                  end_of_sample_o,
  output logic                  loop_block_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  logic phase_q;
  logic out_valid_q;
  logic signed [15:0] newer_q, older_q;
  logic signed [15:0] pcm_q;
  logic pair_q, eos_q, loop_q;

  logic load, clr;
  logic [3:0] nib;
  logic signed [15:0] newer_eff, older_eff, nib_term;
  logic signed [23:0] prod_n, prod_o;
  logic signed [24:0] acc;
  logic signed [18:0] pred;
  logic signed [19:0] total;
  logic signed [15:0] sample;

  always_comb begin
    load      = valid_i && (!out_valid_q || out_ready_i);
    clr       = entry_i.clear_taps && !phase_q;
    nib       = phase_q ? entry_i.data[7:4] : entry_i.data[3:0];
    newer_eff = clr ? 16'sd0 : newer_q;
    older_eff = clr ? 16'sd0 : older_q;
    nib_term  = $signed({nib, 12'h000}) >>> entry_i.shift;
    prod_n    = newer_eff * spu_adpcm_pkg::coef_newer(entry_i.filter);
    prod_o    = older_eff * spu_adpcm_pkg::coef_older(entry_i.filter);
    acc       = {prod_n[23], prod_n} + {prod_o[23], prod_o} + 25'sd32;
    // divide by 64 rounding toward zero
    if (acc[24]) pred = 19'((acc + 25'sd63) >>> 6);
    else         pred = 19'(acc >>> 6);
    total     = {{4{nib_term[15]}}, nib_term} + {pred[18], pred};
    if (total > 20'sd32767)       sample = 16'sh7fff;
    else if (total < -20'sd32768) sample = 16'sh8000;
    else                          sample = total[15:0];
    pop_o     = load && phase_q;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pcm_q  <= sample;
      pair_q <= phase_q;
      eos_q  <= phase_q && entry_i.last_byte && entry_i.flags[0];
      loop_q <= (entry_i.flags == spu_adpcm_pkg::LoopFlags);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      newer_q     <= '0;
      older_q     <= '0;
    end else begin
      if (load) begin
        phase_q     <= !phase_q;
        out_valid_q <= 1'b1;
        older_q     <= newer_eff;
        newer_q     <= sample;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pcm_sample_o    = pcm_q;
  assign pair_last_o     = pair_q;
  assign end_of_sample_o = eos_q;
  assign loop_block_o    = loop_q;
  assign out_valid_o     = out_valid_q;

endmodule

@@ rtl/spu_adpcm_decoder_top.sv @@
// Top level of the SPU ADPCM block decoder.
// Samples: a data byte that reaches the back end gives its first sample, then its
//   second, each through the output register; header bytes give no output.
// Throughput: one sample per cycle while the output is not stalled; the second nibble
//   depends on the taps written by the first; header bytes take one input transfer.
// Reset: asynchronous active low; clears framing, header context, taps and queue.
`timescale 1ns / 1ps

module spu_adpcm_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               start_of_stream_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pcm_sample_o,
  output logic               pair_last_o,
  output logic               end_of_sample_o,
  output logic               loop_block_o
);

  logic                  accept;
  logic                  push, pop, full, q_valid;
  spu_adpcm_pkg::entry_t f_entry, q_entry;

  // Input transfers are taken whenever the queue has room; header bytes never
  // enter the queue, they only update the front end's block context.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  spu_adpcm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .push_o            (push),
    .entry_o           (f_entry)
  );

  // Decouples byte intake from the per-nibble sample loop.
  spu_adpcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // Holds the prediction taps; pops an entry after its high nibble is decoded.
  spu_adpcm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (q_entry),
    .pop_o           (pop),
    .pcm_sample_o    (pcm_sample_o),
    .pair_last_o     (pair_last_o),
    .end_of_sample_o (end_of_sample_o),
    .loop_block_o    (loop_block_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule
